/* rtl/usvt_pkg.sv */
// ----------------------------------------------------------------------------
// usvt_pkg
// Shared types and constants for the unordered value set table: field
// widths, operation and status codes, and the memory command bundle.
// ----------------------------------------------------------------------------
package usvt_pkg;

	// default sizing of the table
	localparam int CAPACITY_DEF    = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	// fixed widths of the item fields
	localparam int FUNC_W  = 3;
	localparam int FIELD_W = 32;
	localparam int STAT_W  = 2;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH    = 3'd0,
		FN_POP     = 3'd1,
		FN_FIND    = 3'd2,
		FN_REPLACE = 3'd3,
		FN_DELETE  = 3'd4,
		FN_CLEAR   = 3'd5
	} func_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// single-port memory command
	typedef struct packed {
		logic re;
		logic we;
	} mem_cmd_t;

endpackage

/* rtl/usvt_mem.sv */
// ----------------------------------------------------------------------------
// usvt_mem
// Single-port entry storage: one read or one write per cycle, registered
// read data that holds until the next read.
// ----------------------------------------------------------------------------
module usvt_mem #(
	parameter int DEPTH = usvt_pkg::CAPACITY_DEF,
	parameter int WIDTH = usvt_pkg::VALUE_WIDTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  usvt_pkg::mem_cmd_t  cmd,
	input  logic [AW-1:0]       addr,
	input  logic [WIDTH-1:0]    wdata,
	output logic [WIDTH-1:0]    rdata
);
	import usvt_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// storage array with registered read port
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem_q[addr] <= wdata;
		end else if (cmd.re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/usvt_ctrl.sv */
// ----------------------------------------------------------------------------
// usvt_ctrl
// Sequencer for the value set: decodes a request, walks the entries one
// memory read per cycle through a single key comparator, performs the
// write-back and holds the result in an output register.
// ----------------------------------------------------------------------------
module usvt_ctrl #(
	parameter int CAPACITY    = usvt_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = usvt_pkg::VALUE_WIDTH_DEF,
	parameter int AW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [usvt_pkg::FUNC_W-1:0]      func,
	input  logic [usvt_pkg::FIELD_W-1:0]     key,
	input  logic [usvt_pkg::FIELD_W-1:0]     new_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [usvt_pkg::STAT_W-1:0]      status,
	output logic [usvt_pkg::INDEX_W-1:0]     index,
	output logic [usvt_pkg::FIELD_W-1:0]     value,
	output logic [usvt_pkg::COUNT_W-1:0]     count,
	output usvt_pkg::mem_cmd_t               mem_cmd,
	output logic [AW-1:0]                    mem_addr,
	output logic [VALUE_WIDTH-1:0]           mem_wdata,
	input  logic [VALUE_WIDTH-1:0]           mem_rdata
);
	import usvt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_SCAN = 5'b00100,
		S_TAKE = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [FUNC_W-1:0]    func_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [VALUE_WIDTH-1:0] nv_q;

	// scan walk
	logic [CW-1:0]        addr_q;
	logic                 pend_q;
	logic [AW-1:0]        pidx_q;
	logic [AW-1:0]        pos_q;

	// result being built and the output register
	status_t              res_status_q;
	logic [AW-1:0]        res_index_q;
	logic [VALUE_WIDTH-1:0] res_value_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [AW-1:0]        out_index_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic [CW-1:0]        out_count_q;

	logic                 is_full;
	logic                 is_empty;
	logic [CW-1:0]        last_c;
	logic                 scan_hit;
	logic                 scan_end;
	logic                 out_free;

	assign is_full  = (count_q == CAP_C);
	assign is_empty = (count_q == '0);
	assign last_c   = count_q - CW'(1);
	// shared key comparator on the registered read data
	assign scan_hit = pend_q && (mem_rdata == key_q);
	assign scan_end = (addr_q == count_q);
	assign out_free = !out_valid_q || out_ready;

	assign in_ready = (state_q == S_IDLE);

	// memory port steering
	always_comb begin
		mem_cmd   = '0;
		mem_addr  = '0;
		mem_wdata = key_q;
		case (state_q)
			S_EXEC: begin
				if (func_q == FN_PUSH && !is_full) begin
					mem_cmd.we = 1'b1;
					mem_addr   = count_q[AW-1:0];
				end else if (func_q == FN_POP && !is_empty) begin
					mem_cmd.re = 1'b1;
					mem_addr   = last_c[AW-1:0];
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					if (func_q == FN_REPLACE) begin
						mem_cmd.we = 1'b1;
						mem_addr   = pidx_q;
						mem_wdata  = nv_q;
					end else if (func_q == FN_DELETE) begin
						mem_cmd.re = 1'b1;
						mem_addr   = last_c[AW-1:0];
					end
				end else if (!scan_end) begin
					mem_cmd.re = 1'b1;
					mem_addr   = addr_q[AW-1:0];
				end
			end
			S_TAKE: begin
				if (func_q == FN_DELETE) begin
					mem_cmd.we = 1'b1;
					mem_addr   = pos_q;
					mem_wdata  = mem_rdata;
				end
			end
			default: ;
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result drained; a reload in S_DONE keeps it valid instead
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					pend_q <= 1'b0;
					case (func_q)
						FN_PUSH: begin
							if (!is_full) begin
								count_q <= count_q + CW'(1);
							end
							state_q <= S_DONE;
						end
						FN_POP: begin
							state_q <= is_empty ? S_DONE : S_TAKE;
						end
						FN_FIND, FN_REPLACE: begin
							state_q <= S_SCAN;
						end
						FN_DELETE: begin
							state_q <= is_empty ? S_DONE : S_SCAN;
						end
						FN_CLEAR: begin
							count_q <= '0;
							state_q <= S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SCAN: begin
					if (scan_hit) begin
						pend_q  <= 1'b0;
						state_q <= (func_q == FN_DELETE) ? S_TAKE : S_DONE;
					end else if (scan_end) begin
						pend_q  <= 1'b0;
						state_q <= S_DONE;
					end else begin
						pend_q <= 1'b1;
					end
				end
				S_TAKE: begin
					count_q <= last_c;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture, scan pointers and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= func;
				key_q  <= VALUE_WIDTH'(key);
				nv_q   <= VALUE_WIDTH'(new_value);
			end
			S_EXEC: begin
				addr_q       <= '0;
				res_index_q  <= '0;
				res_value_q  <= '0;
				if (func_q == FN_PUSH && is_full) begin
					res_status_q <= ST_FULL;
				end else if ((func_q == FN_POP || func_q == FN_DELETE) && is_empty) begin
					res_status_q <= ST_EMPTY;
				end else begin
					res_status_q <= ST_OK;
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					pos_q       <= pidx_q;
					res_index_q <= pidx_q;
				end else if (scan_end) begin
					res_status_q <= ST_MISSING;
				end else begin
					pidx_q <= addr_q[AW-1:0];
					addr_q <= addr_q + CW'(1);
				end
			end
			S_TAKE: begin
				if (func_q == FN_POP) begin
					res_value_q <= mem_rdata;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_index_q  <= res_index_q;
					out_value_q  <= res_value_q;
					out_count_q  <= count_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign index     = INDEX_W'(out_index_q);
	assign value     = FIELD_W'(out_value_q);
	assign count     = COUNT_W'(out_count_q);

endmodule

/* rtl/unordered_value_set_table.sv */
// ----------------------------------------------------------------------------
// unordered_value_set_table
// Unordered list of up to CAPACITY values with push, pop, find, replace,
// swap-remove delete and clear, one result per request.
// ----------------------------------------------------------------------------
// A request is taken only while the sequencer is idle and occupies it until
// its result is written to the output register; the next request can be
// taken while that result still waits. Push, clear, unused codes and pop or
// delete of an empty list pass from the exec state to the done state; any
// other pop reads the last entry and takes it in the take state. Find,
// replace and delete read entries in the scan state up to and including
// the first match, or all entries when the value is absent: the single-port
// entry memory delivers one entry per cycle to one shared key comparator.
// Delete then moves the last entry into the freed slot in the take state.
// An undrained full output register holds the sequencer in its done state.
module unordered_value_set_table #(
	parameter int CAPACITY    = usvt_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = usvt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [usvt_pkg::FUNC_W-1:0]   func,
	input  logic [usvt_pkg::FIELD_W-1:0]  key,
	input  logic [usvt_pkg::FIELD_W-1:0]  new_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [usvt_pkg::STAT_W-1:0]   status,
	output logic [usvt_pkg::INDEX_W-1:0]  index,
	output logic [usvt_pkg::FIELD_W-1:0]  value,
	output logic [usvt_pkg::COUNT_W-1:0]  count
);
	import usvt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	mem_cmd_t               mem_cmd;
	logic [AW-1:0]          mem_addr;
	logic [VALUE_WIDTH-1:0] mem_wdata;
	logic [VALUE_WIDTH-1:0] mem_rdata;

	// sequencer, comparator and output register
	usvt_ctrl #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.key       (key),
		.new_value (new_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.index     (index),
		.value     (value),
		.count     (count),
		.mem_cmd   (mem_cmd),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	// entry storage
	usvt_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.cmd   (mem_cmd),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

/* rtl/usvt_chk.sv */
// ----------------------------------------------------------------------------
// usvt_chk
// Port-level checks for the unordered value set table, attached to the top
// level by a bind statement.
// ----------------------------------------------------------------------------
module usvt_chk #(
	parameter int CAPACITY = usvt_pkg::CAPACITY_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [usvt_pkg::STAT_W-1:0]   status,
	input logic [usvt_pkg::INDEX_W-1:0]  index,
	input logic [usvt_pkg::FIELD_W-1:0]  value,
	input logic [usvt_pkg::COUNT_W-1:0]  count
);
	import usvt_pkg::*;

	localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(index)
			&& $stable(value) && $stable(count))
		else $error("result changed while stalled");

	// a full report comes only from a list at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> count == CAP_C && value == '0)
		else $error("full status with count below capacity");

	// an empty report comes only from an empty list
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> count == '0 && value == '0 && index == '0)
		else $error("empty status with entries present");

	// a missing value reports no index and no value
	a_missing_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_MISSING |-> index == '0 && value == '0)
		else $error("not-found result carries data");

	// the count never exceeds capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> CAPACITY > 127 || count <= CAP_C)
		else $error("count above capacity");

endmodule

bind unordered_value_set_table usvt_chk #(
	.CAPACITY (CAPACITY)
) u_usvt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.index     (index),
	.value     (value),
	.count     (count)
);
